// ----- rtl/pidl_pkg.sv -----
// Package for the positional insert/delete list.
// Field widths, command and status codes, controller states and the
// controller/datapath handshake structs. No dependencies.
package pidl_pkg;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_READ   = 2'd2;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;
  localparam status_t STATUS_RANGE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the incoming transaction
    logic decode;  // check the command against the count, set up the shift
    logic shift;   // move one entry per cycle
    logic finish;  // final write, count update, load the result register
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic go_shift;     // decoded command needs entries moved
    logic remain_zero;  // no more reads to issue
    logic out_free;     // result register can take a new result
  } stat_t;

endpackage

// ----- rtl/pidl_cmd_if.sv -----
// Command channel of the positional insert/delete list.
// Depends on pidl_pkg.
interface pidl_cmd_if;
  logic                           valid;
  logic                           ready;
  pidl_pkg::cmd_t                 command;
  logic [pidl_pkg::POS_W-1:0]     position;
  logic [pidl_pkg::WORD_W-1:0]    entry_data;

  modport source (output valid, command, position, entry_data, input ready);
  modport sink   (input valid, command, position, entry_data, output ready);
endinterface

// ----- rtl/pidl_rsp_if.sv -----
// Result channel of the positional insert/delete list.
// Depends on pidl_pkg.
interface pidl_rsp_if;
  logic                           valid;
  logic                           ready;
  pidl_pkg::status_t              status;
  logic [pidl_pkg::WORD_W-1:0]    read_data;
  logic [pidl_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, status, read_data, entry_count, input ready);
  modport sink   (input valid, status, read_data, entry_count, output ready);
endinterface

// ----- rtl/positional_insert_delete_list.sv -----
// Positional insert/delete list, top level.
// Depends on pidl_pkg, pidl_cmd_if, pidl_rsp_if, pidl_ctrl, pidl_datapath.
//
// Usage:
//   cmd (sink): one transaction per command: command (insert, delete, read),
//     position and entry_data. Accepted when valid and ready are both high.
//   rsp (source): exactly one transaction per command: status, read_data
//     (the entry for a good read, zero otherwise) and entry_count after the
//     command.
//   Entries live in a single-port-read, single-port-write memory. Insert and
//   delete move every entry above the target position by one place, one
//   entry per cycle through the registered memory read.
// Sequence: a command is latched, then decoded; an insert or delete that
//   moves entries passes through the shift state, then every command ends
//   at its final step, which loads the result register.
//   One command is worked at a time; ready returns the cycle after the
//   result is loaded.
// Reset: rst is synchronous; it empties the list (count zero) and drops
//   rsp.valid. Memory contents are not cleared, none is ever read unwritten.
// Stall: the result waits in an output register; a new command is taken
//   meanwhile and is held at its final step until the register frees.
module positional_insert_delete_list #(
  parameter int DEPTH      = pidl_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  pidl_cmd_if.sink   cmd,
  pidl_rsp_if.source rsp
);

  pidl_pkg::ctrl_t ctrl;
  pidl_pkg::stat_t stat;

  pidl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  pidl_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .command     (cmd.command),
    .position    (cmd.position),
    .entry_data  (cmd.entry_data),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .read_data   (rsp.read_data),
    .entry_count (rsp.entry_count)
  );

endmodule

// ----- rtl/pidl_ctrl.sv -----
// Sequencer of the positional insert/delete list.
// Depends on pidl_pkg; drives pidl_datapath through pidl_pkg::ctrl_t.
module pidl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pidl_pkg::stat_t stat,
  output pidl_pkg::ctrl_t ctrl
);

  pidl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    case (state)
      pidl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = pidl_pkg::S_DECODE;
        end
      end
      pidl_pkg::S_DECODE: begin
        ctrl.decode = 1'b1;
        state_next  = stat.go_shift ? pidl_pkg::S_SHIFT : pidl_pkg::S_DONE;
      end
      pidl_pkg::S_SHIFT: begin
        ctrl.shift = 1'b1;
        // last pending write lands in this cycle
        if (stat.remain_zero) begin
          state_next = pidl_pkg::S_DONE;
        end
      end
      pidl_pkg::S_DONE: begin
        if (stat.out_free) begin
          ctrl.finish = 1'b1;
          state_next  = pidl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pidl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/pidl_datapath.sv -----
// Datapath of the positional insert/delete list: entry memory, count,
// shift address counters and the result register. Depends on pidl_pkg.
module pidl_datapath #(
  parameter int DEPTH      = pidl_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pidl_pkg::ctrl_t                 ctrl,
  output pidl_pkg::stat_t                 stat,
  input  pidl_pkg::cmd_t                  command,
  input  logic [pidl_pkg::POS_W-1:0]      position,
  input  logic [pidl_pkg::WORD_W-1:0]     entry_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pidl_pkg::status_t               status,
  output logic [pidl_pkg::WORD_W-1:0]     read_data,
  output logic [pidl_pkg::COUNT_W-1:0]    entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  pidl_pkg::cmd_t             cmd_q;
  logic [pidl_pkg::POS_W-1:0] pos_q;
  logic [DATA_WIDTH-1:0]      word_q;
  logic [CW-1:0]              count;
  pidl_pkg::status_t          st_q;
  logic                       rd_ok_q;
  logic [AW-1:0]              posc_q;
  logic [AW-1:0]              src;
  logic [AW-1:0]              dst_q;
  logic [CW-1:0]              remain;
  logic                       rd_pend;
  logic [DATA_WIDTH-1:0]      rd_q;

  // decode
  logic [PW-1:0]     pos_ext, cnt_ext, pos_clamp;
  pidl_pkg::status_t st_dec;
  logic              ins_ok, del_ok, read_ok;
  logic [CW-1:0]     ins_remain, del_remain;

  // memory ports
  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  logic          is_ins;
  logic [CW-1:0] count_new;

  assign is_ins  = (cmd_q == pidl_pkg::CMD_INSERT);
  assign pos_ext = PW'(pos_q);
  assign cnt_ext = PW'(count);
  assign pos_clamp  = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
  assign ins_remain = CW'(cnt_ext - pos_clamp);
  assign del_remain = CW'(cnt_ext - pos_ext - PW'(1));

  always_comb begin
    st_dec  = pidl_pkg::STATUS_OK;
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    read_ok = 1'b0;
    case (cmd_q)
      pidl_pkg::CMD_INSERT: begin
        if (count == CW'(DEPTH)) st_dec = pidl_pkg::STATUS_FULL;
        else                     ins_ok = 1'b1;
      end
      pidl_pkg::CMD_DELETE: begin
        if (count == '0)             st_dec = pidl_pkg::STATUS_EMPTY;
        else if (pos_ext >= cnt_ext) st_dec = pidl_pkg::STATUS_RANGE;
        else                         del_ok = 1'b1;
      end
      pidl_pkg::CMD_READ: begin
        if (count == '0)             st_dec  = pidl_pkg::STATUS_EMPTY;
        else if (pos_ext >= cnt_ext) st_dec  = pidl_pkg::STATUS_RANGE;
        else                         read_ok = 1'b1;
      end
      default: begin
        st_dec = pidl_pkg::STATUS_OK;  // unused code: no change
      end
    endcase
  end

  assign stat.go_shift    = (ins_ok && ins_remain != '0) || (del_ok && del_remain != '0);
  assign stat.remain_zero = (remain == '0);
  assign stat.out_free    = !out_valid || out_ready;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = src;
    wr_en   = 1'b0;
    wr_addr = dst_q;
    wr_data = rd_q;
    if (ctrl.decode && read_ok) begin
      rd_en   = 1'b1;
      rd_addr = AW'(pos_ext);
    end
    if (ctrl.shift) begin
      rd_en = (remain != '0);
      wr_en = rd_pend;
    end
    if (ctrl.finish && is_ins && st_q == pidl_pkg::STATUS_OK) begin
      wr_en   = 1'b1;
      wr_addr = posc_q;
      wr_data = word_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // transaction and shift registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= command;
      pos_q  <= position;
      word_q <= DATA_WIDTH'(entry_data);
    end
    if (ctrl.decode) begin
      st_q    <= st_dec;
      rd_ok_q <= read_ok;
      posc_q  <= AW'(pos_clamp);
      remain  <= ins_ok ? ins_remain : (del_ok ? del_remain : '0);
      src     <= is_ins ? AW'(cnt_ext - PW'(1)) : AW'(pos_ext + PW'(1));
    end
    if (ctrl.shift && remain != '0) begin
      src    <= is_ins ? src - AW'(1) : src + AW'(1);
      dst_q  <= is_ins ? src + AW'(1) : src - AW'(1);
      remain <= remain - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (ctrl.decode) begin
      rd_pend <= 1'b0;
    end else if (ctrl.shift) begin
      rd_pend <= (remain != '0);
    end
  end

  always_comb begin
    count_new = count;
    if (st_q == pidl_pkg::STATUS_OK) begin
      if (is_ins)                               count_new = count + CW'(1);
      else if (cmd_q == pidl_pkg::CMD_DELETE)   count_new = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.finish) begin
      count <= count_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      status      <= st_q;
      read_data   <= rd_ok_q ? pidl_pkg::WORD_W'(rd_q) : '0;
      entry_count <= pidl_pkg::COUNT_W'(count_new);
    end
  end

endmodule

// ----- rtl/pidl_checker.sv -----
// Port-level checks for positional_insert_delete_list, bound to the top.
// Depends on pidl_pkg.
module pidl_checker #(
  parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input pidl_pkg::status_t              rsp_status,
  input logic [pidl_pkg::WORD_W-1:0]    rsp_read_data,
  input logic [pidl_pkg::COUNT_W-1:0]   rsp_entry_count
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_read_data) && $stable(rsp_entry_count))
    else $error("result changed while stalled");

  // failed commands return no data
  a_err_nodata: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != pidl_pkg::STATUS_OK |-> rsp_read_data == '0)
    else $error("read_data nonzero on error status");

  // empty status only reported with an empty list
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == pidl_pkg::STATUS_EMPTY |-> rsp_entry_count == '0)
    else $error("empty status with nonzero count");

  // full status only reported with a full list
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == pidl_pkg::STATUS_FULL |->
      rsp_entry_count == pidl_pkg::COUNT_W'(DEPTH))
    else $error("full status with count below depth");

  // count never above depth
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (DEPTH >= 32) || (int'(rsp_entry_count) <= DEPTH))
    else $error("entry_count above depth");

endmodule

bind positional_insert_delete_list pidl_checker #(.DEPTH(DEPTH)) u_pidl_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_read_data   (rsp.read_data),
  .rsp_entry_count (rsp.entry_count)
);

// ----- test/tb.sv -----
// Self-checking testbench for positional_insert_delete_list.
// Depends on pidl_pkg, pidl_cmd_if, pidl_rsp_if and the RTL top level; drives
// command transactions, mirrors the list in a queue and checks every result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int             LIST_DEPTH   = pidl_pkg::DEPTH_DEF;
  localparam int             IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int             DRAIN_CYCLES = 40;    // settle time after the last result
  localparam int             RANDOM_ITEMS = 1420;
  localparam pidl_pkg::cmd_t CMD_UNUSED   = 2'd3;  // spare code, must be a no-op

  typedef struct {
    pidl_pkg::status_t                status;
    logic [pidl_pkg::WORD_W-1:0]      read_data;
    logic [pidl_pkg::COUNT_W-1:0]     entry_count;
  } list_result_t;

  logic clk;
  logic rst;

  pidl_cmd_if cmd_bus();
  pidl_rsp_if rsp_bus();

  positional_insert_delete_list dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  // Mirror of the list contents: index 0 is the front. Its size is the count.
  logic [pidl_pkg::WORD_W-1:0] mirror_list[$];
  // Results owed by the block, oldest first.
  list_result_t                pending_results[$];

  int mismatches = 0;
  int src_pct    = 0;  // chance per command of a gap before it
  int sink_pct   = 0;  // chance per cycle of a result stall starting

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // Apply one command to the mirror and return what the block must answer.
  // Insert clamps a position past the end to an append; delete/read check
  // for an empty list first, then for a position at or past the count.
  function automatic list_result_t predict_list_op(
      input pidl_pkg::cmd_t                op,
      input logic [pidl_pkg::POS_W-1:0]   pos,
      input logic [pidl_pkg::WORD_W-1:0]  word);
    list_result_t res;
    int           slot;
    res.status    = pidl_pkg::STATUS_OK;
    res.read_data = '0;
    slot          = int'(pos);
    case (op)
      pidl_pkg::CMD_INSERT: begin
        if (mirror_list.size() >= LIST_DEPTH) begin
          res.status = pidl_pkg::STATUS_FULL;
        end else begin
          if (slot > mirror_list.size()) slot = mirror_list.size();
          mirror_list.insert(slot, word);
        end
      end
      pidl_pkg::CMD_DELETE: begin
        if (mirror_list.size() == 0) res.status = pidl_pkg::STATUS_EMPTY;
        else if (slot >= mirror_list.size()) res.status = pidl_pkg::STATUS_RANGE;
        else mirror_list.delete(slot);
      end
      pidl_pkg::CMD_READ: begin
        if (mirror_list.size() == 0) res.status = pidl_pkg::STATUS_EMPTY;
        else if (slot >= mirror_list.size()) res.status = pidl_pkg::STATUS_RANGE;
        else res.read_data = mirror_list[slot];
      end
      default: ;  // spare code: no change
    endcase
    res.entry_count = pidl_pkg::COUNT_W'(mirror_list.size());
    return res;
  endfunction

  // Send one command transaction. Valid stays high into the next call when no
  // gap is drawn, so back-to-back commands never drop valid for a cycle.
  task automatic send_cmd(input pidl_pkg::cmd_t               op,
                          input logic [pidl_pkg::POS_W-1:0]  pos,
                          input logic [pidl_pkg::WORD_W-1:0] word);
    int gap;
    gap = gap_len(src_pct);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= op;
    cmd_bus.position   <= pos;
    cmd_bus.entry_data <= word;
    do @(posedge clk); while (!cmd_bus.ready);
    pending_results.push_back(predict_list_op(op, pos, word));
  endtask

  // Hold off the sender until the block has answered everything.
  task automatic pause_until_drained();
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty list: delete and read must flag empty, the spare code does nothing.
  task automatic test_empty_list();
    send_cmd(pidl_pkg::CMD_DELETE, 8'd0,   32'h1234_5678);
    send_cmd(pidl_pkg::CMD_READ,   8'd0,   32'h0);
    send_cmd(pidl_pkg::CMD_DELETE, 8'd255, 32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED,           8'd0,   32'hDEAD_BEEF);
  endtask

  // Front inserts, a clamped append, and reads at the edges of the range.
  task automatic test_insert_front_and_clamp();
    send_cmd(pidl_pkg::CMD_INSERT, 8'd0,   32'h0000_0000);
    send_cmd(pidl_pkg::CMD_INSERT, 8'd0,   32'hFFFF_FFFF);
    send_cmd(pidl_pkg::CMD_INSERT, 8'd255, 32'hA5A5_5A5A);  // past count -> append
    send_cmd(pidl_pkg::CMD_READ,   8'd0,   32'h0);
    send_cmd(pidl_pkg::CMD_READ,   8'd255, 32'h0);
  endtask

  // Fill to capacity, overflow, then delete at the edges.
  task automatic test_fill_to_full();
    while (mirror_list.size() < LIST_DEPTH)
      send_cmd(pidl_pkg::CMD_INSERT,
               pidl_pkg::POS_W'($urandom_range(mirror_list.size(), 0)), $urandom);
    // every result in before the overflow attempt
    pause_until_drained();
    send_cmd(pidl_pkg::CMD_INSERT, 8'd0,   32'h5555_AAAA);  // full -> rejected
    send_cmd(pidl_pkg::CMD_READ,   8'd15,  32'h0);
    send_cmd(pidl_pkg::CMD_DELETE, 8'd16,  32'h0);          // at count -> out of range
    send_cmd(pidl_pkg::CMD_DELETE, 8'd15,  32'h0);          // last entry
    send_cmd(pidl_pkg::CMD_DELETE, 8'd0,   32'h0);          // front entry
    send_cmd(CMD_UNUSED,           8'd255, 32'hFFFF_FFFF);
  endtask

  // Random traffic in phases. Each phase steers the fill level toward a target,
  // mostly empty or full, so the list keeps crossing both ends. Positions are
  // mostly legal, with a share at the count and across the whole field.
  task automatic test_random_traffic(input int n_items);
    int                          done;
    int                          target;
    int                          steps;
    int                          fill;
    int                          r;
    bit                          paused;
    pidl_pkg::cmd_t              op;
    logic [pidl_pkg::POS_W-1:0]  pos;
    logic [pidl_pkg::WORD_W-1:0] word;
    done   = 0;
    paused = 1'b0;
    while (done < n_items) begin
      r = $urandom_range(99);
      if (r < 30) target = LIST_DEPTH;
      else if (r < 55) target = 0;
      else target = $urandom_range(LIST_DEPTH - 1, 1);
      steps    = $urandom_range(40, 8);
      src_pct  = pick_pct();
      sink_pct = pick_pct();
      if (!paused && done >= n_items / 2) begin
        pause_until_drained();
        paused = 1'b1;
      end
      repeat (steps) begin
        fill = mirror_list.size();
        r    = $urandom_range(99);
        if (r < 4) op = CMD_UNUSED;
        else if (r < 28) op = pidl_pkg::CMD_READ;
        else if (fill == target)
          op = $urandom_range(1) ? pidl_pkg::CMD_INSERT : pidl_pkg::CMD_DELETE;
        else if ($urandom_range(99) < 15)
          op = (fill < target) ? pidl_pkg::CMD_DELETE : pidl_pkg::CMD_INSERT;
        else
          op = (fill < target) ? pidl_pkg::CMD_INSERT : pidl_pkg::CMD_DELETE;

        r = $urandom_range(99);
        if (r < 25) pos = pidl_pkg::POS_W'($urandom_range(255, 0));
        else if (r < 35) pos = pidl_pkg::POS_W'(fill);
        else if (op == pidl_pkg::CMD_INSERT || fill == 0)
          pos = pidl_pkg::POS_W'($urandom_range(fill, 0));
        else pos = pidl_pkg::POS_W'($urandom_range(fill - 1, 0));

        r = $urandom_range(99);
        if (r < 5) word = '0;
        else if (r < 10) word = '1;
        else word = $urandom;

        send_cmd(op, pos, word);
        done++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the scoreboard check
  // --------------------------------------------------------------------------

  initial begin
    int hold;
    hold          = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) hold = gap_len(sink_pct);
      if (hold > 0) begin
        rsp_bus.ready <= 1'b0;
        hold--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: status %0d count %0d",
               rsp_bus.status, rsp_bus.entry_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, rsp_bus.status);
          mismatches++;
        end
        if (rsp_bus.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %08h, actual %08h",
                 want.read_data, rsp_bus.read_data);
          mismatches++;
        end
        if (rsp_bus.entry_count !== want.entry_count) begin
          $error("entry_count mismatch: expected %0d, actual %0d",
                 want.entry_count, rsp_bus.entry_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any accepted transaction (or reset) restarts the count.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("positional_insert_delete_list verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst                = 1'b1;
    cmd_bus.valid      = 1'b0;
    cmd_bus.command    = pidl_pkg::CMD_INSERT;
    cmd_bus.position   = '0;
    cmd_bus.entry_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs with light idling on both sides
    src_pct  = 20;
    sink_pct = 20;
    test_empty_list();
    test_insert_front_and_clamp();
    test_fill_to_full();
    test_random_traffic(RANDOM_ITEMS);

    // every result in, then give the block time to show anything stray
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("positional_insert_delete_list verification clean");
    end else begin
      $display("positional_insert_delete_list verification failed");
    end
    $finish;
  end

endmodule
